>>> rtl/core/jfx_pkg.sv
package jfx_pkg;

	localparam int BufferBytesDefault = 4096;
	localparam int QueueDepth         = 2;

	localparam logic [30:0] IdMax = 31'h7FFF_FFFF;

	localparam logic [7:0] ChOpenBrace  = 8'h7B;
	localparam logic [7:0] ChOpenBrack  = 8'h5B;
	localparam logic [7:0] ChCloseBrace = 8'h7D;
	localparam logic [7:0] ChCloseBrack = 8'h5D;
	localparam logic [7:0] ChQuote      = 8'h22;
	localparam logic [7:0] ChBackslash  = 8'h5C;
	localparam logic [7:0] ChLowerI     = 8'h69;
	localparam logic [7:0] ChLowerD     = 8'h64;
	localparam logic [7:0] ChColon      = 8'h3A;
	localparam logic [7:0] ChTab        = 8'h09;
	localparam logic [7:0] ChLineFeed   = 8'h0A;
	localparam logic [7:0] ChVertTab    = 8'h0B;
	localparam logic [7:0] ChFormFeed   = 8'h0C;
	localparam logic [7:0] ChReturn     = 8'h0D;
	localparam logic [7:0] ChSpace      = 8'h20;
	localparam logic [7:0] ChPlus       = 8'h2B;
	localparam logic [7:0] ChMinus      = 8'h2D;
	localparam logic [7:0] ChZero       = 8'h30;
	localparam logic [7:0] ChNine       = 8'h39;
	localparam logic [7:0] ChNul        = 8'h00;

	typedef enum logic [2:0] {
		PH_SCAN   = 3'd0,
		PH_KEY    = 3'd1,
		PH_COLON  = 3'd2,
		PH_VALUE  = 3'd3,
		PH_SIGN   = 3'd4,
		PH_DIGITS = 3'd5,
		PH_NONE   = 3'd6,
		PH_FOUND  = 3'd7
	} key_phase_t;

	typedef struct packed {
		logic       is_quote;
		logic       is_bslash;
		logic       is_open;
		logic       is_close;
		logic       is_colon;
		logic       is_ws4;
		logic       is_ws_extra;
		logic       is_plus;
		logic       is_minus;
		logic       is_digit;
		logic       is_nul;
		logic       is_i;
		logic       is_d;
		logic [3:0] digit;
	} byte_class_t;

	typedef struct packed {
		byte_class_t cls;
		logic        first;
		logic [7:0]  size;
		logic        last;
	} word_t;

endpackage

>>> rtl/core/jfx_front.sv
module jfx_front (
	input  logic          [7:0] data_byte,
	input  logic                first_of_chunk,
	input  logic          [7:0] chunk_bytes,
	input  logic                last_of_chunk,
	output jfx_pkg::word_t      word
);

	logic [7:0] dsub;

	assign dsub = data_byte - jfx_pkg::ChZero;

	always_comb begin
		word.cls.is_quote    = (data_byte == jfx_pkg::ChQuote);
		word.cls.is_bslash   = (data_byte == jfx_pkg::ChBackslash);
		word.cls.is_open     = (data_byte == jfx_pkg::ChOpenBrace) ||
			(data_byte == jfx_pkg::ChOpenBrack);
		word.cls.is_close    = (data_byte == jfx_pkg::ChCloseBrace) ||
			(data_byte == jfx_pkg::ChCloseBrack);
		word.cls.is_colon    = (data_byte == jfx_pkg::ChColon);
		word.cls.is_ws4      = (data_byte == jfx_pkg::ChSpace) ||
			(data_byte == jfx_pkg::ChTab) || (data_byte == jfx_pkg::ChReturn) ||
			(data_byte == jfx_pkg::ChLineFeed);
		word.cls.is_ws_extra = (data_byte == jfx_pkg::ChVertTab) ||
			(data_byte == jfx_pkg::ChFormFeed);
		word.cls.is_plus     = (data_byte == jfx_pkg::ChPlus);
		word.cls.is_minus    = (data_byte == jfx_pkg::ChMinus);
		word.cls.is_digit    = (data_byte >= jfx_pkg::ChZero) &&
			(data_byte <= jfx_pkg::ChNine);
		word.cls.is_nul      = (data_byte == jfx_pkg::ChNul);
		word.cls.is_i        = (data_byte == jfx_pkg::ChLowerI);
		word.cls.is_d        = (data_byte == jfx_pkg::ChLowerD);
		word.cls.digit       = dsub[3:0];
		word.first           = first_of_chunk;
		word.size            = chunk_bytes;
		word.last            = last_of_chunk;
	end

endmodule

>>> rtl/core/jfx_queue.sv
module jfx_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_stall,
	input  jfx_pkg::word_t push_word,
	output logic           pop_valid,
	input  logic           pop_stall,
	output jfx_pkg::word_t pop_word
);

	localparam int Depth = jfx_pkg::QueueDepth;
	localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW  = $clog2(Depth + 1);

	jfx_pkg::word_t entry_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_stall = (count_q == CntW'(Depth));
	assign pop_valid  = (count_q != '0);
	assign pop_word   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && !push_stall;
	assign do_pop     = pop_valid && !pop_stall;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/jfx_back.sv
module jfx_back #(
	parameter int BUFFER_BYTES = jfx_pkg::BufferBytesDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           word_valid,
	output logic           word_stall,
	input  jfx_pkg::word_t word,
	output logic           result_valid,
	input  logic           result_stall,
	output logic    [11:0] frame_length,
	output logic           id_present,
	output logic    [30:0] id_number
);

	localparam int FillW  = $clog2(BUFFER_BYTES);
	localparam int DepthW = FillW + 1;
	localparam int SumW   = $clog2(BUFFER_BYTES + 256);

	typedef struct packed {
		logic        [FillW-1:0]  fill;
		logic signed [DepthW-1:0] depth;
		logic                     seen_open;
		logic                     in_str;
		logic                     esc;
		jfx_pkg::key_phase_t      phase;
		logic        [1:0]        kcnt;
		logic                     kmatch;
		logic                     neg;
		logic        [30:0]       mag;
	} frame_t;

	frame_t      frame_q;
	frame_t      frame_n;
	logic        drop_q;
	logic        drop_n;
	logic        pop;
	logic        emit;
	logic        present;
	logic [34:0] prod;
	logic        valid_q;
	logic [11:0] len_q;
	logic        present_q;
	logic [30:0] number_q;

	assign word_stall = valid_q && result_stall;
	assign pop        = word_valid && !word_stall;

	// mag * 10 + digit, wide enough to never wrap
	assign prod = ({4'b0, frame_q.mag} << 3) + ({4'b0, frame_q.mag} << 1) +
		35'(word.cls.digit);

	always_comb begin
		jfx_pkg::key_phase_t ph;
		logic                go;
		frame_n = frame_q;
		drop_n  = drop_q;
		emit    = 1'b0;
		present = 1'b0;
		ph      = frame_q.phase;
		go      = 1'b1;
		if (pop) begin
			if (word.first) begin
				drop_n = 1'b0;
				if (SumW'(frame_q.fill) + SumW'(word.size) >= SumW'(BUFFER_BYTES)) begin
					frame_n = '0;
					drop_n  = 1'b1;
				end
			end
			if (!drop_n) begin
				if (SumW'(frame_q.fill) + SumW'(1) >= SumW'(BUFFER_BYTES)) begin
					frame_n = '0;
					drop_n  = 1'b1;
				end else begin
					frame_n.fill = frame_q.fill + 1'b1;
					// id scanner sees the flags from before this byte
					if (ph == jfx_pkg::PH_COLON) begin
						if (word.cls.is_ws4) begin
							go = 1'b0;
						end else if (word.cls.is_colon) begin
							frame_n.phase = jfx_pkg::PH_VALUE;
							go = 1'b0;
						end else begin
							ph = jfx_pkg::PH_SCAN;
						end
					end
					if (go) begin
						frame_n.phase = ph;
						unique case (ph)
							jfx_pkg::PH_SCAN: begin
								if (word.cls.is_nul) begin
									frame_n.phase = jfx_pkg::PH_NONE;
								end else if (word.cls.is_quote) begin
									frame_n.phase  = jfx_pkg::PH_KEY;
									frame_n.kcnt   = 2'd0;
									frame_n.kmatch = 1'b1;
								end
							end
							jfx_pkg::PH_KEY: begin
								if (word.cls.is_nul) begin
									frame_n.phase = jfx_pkg::PH_NONE;
								end else if (!frame_q.esc && word.cls.is_quote) begin
									if (frame_q.depth == DepthW'(1) && frame_q.kcnt == 2'd2 &&
										frame_q.kmatch) begin
										frame_n.phase = jfx_pkg::PH_COLON;
									end else begin
										frame_n.phase = jfx_pkg::PH_SCAN;
									end
								end else begin
									if (frame_q.kcnt == 2'd0 && !word.cls.is_i) begin
										frame_n.kmatch = 1'b0;
									end
									if (frame_q.kcnt == 2'd1 && !word.cls.is_d) begin
										frame_n.kmatch = 1'b0;
									end
									if (frame_q.kcnt != 2'd3) begin
										frame_n.kcnt = frame_q.kcnt + 1'b1;
									end
								end
							end
							jfx_pkg::PH_VALUE: begin
								if (word.cls.is_ws4 || word.cls.is_ws_extra) begin
									frame_n.phase = jfx_pkg::PH_VALUE;
								end else if (word.cls.is_plus || word.cls.is_minus) begin
									frame_n.neg   = word.cls.is_minus;
									frame_n.phase = jfx_pkg::PH_SIGN;
								end else if (word.cls.is_digit) begin
									frame_n.mag   = 31'(word.cls.digit);
									frame_n.phase = jfx_pkg::PH_DIGITS;
								end else begin
									frame_n.phase = jfx_pkg::PH_NONE;
								end
							end
							jfx_pkg::PH_SIGN: begin
								if (word.cls.is_digit) begin
									frame_n.mag   = 31'(word.cls.digit);
									frame_n.phase = jfx_pkg::PH_DIGITS;
								end else begin
									frame_n.phase = jfx_pkg::PH_NONE;
								end
							end
							jfx_pkg::PH_DIGITS: begin
								if (word.cls.is_digit) begin
									frame_n.mag = (prod > 35'(jfx_pkg::IdMax)) ?
										jfx_pkg::IdMax : prod[30:0];
								end else if (frame_q.neg && frame_q.mag != '0) begin
									frame_n.phase = jfx_pkg::PH_NONE;
								end else begin
									frame_n.phase = jfx_pkg::PH_FOUND;
								end
							end
							default: begin
								frame_n.phase = ph;
							end
						endcase
					end
					// bracket and string tracking
					if (frame_q.in_str) begin
						if (frame_q.esc) begin
							frame_n.esc = 1'b0;
						end else if (word.cls.is_bslash) begin
							frame_n.esc = 1'b1;
						end else if (word.cls.is_quote) begin
							frame_n.in_str = 1'b0;
						end
					end else if (word.cls.is_quote) begin
						frame_n.in_str = 1'b1;
					end else if (word.cls.is_open) begin
						frame_n.depth     = frame_q.depth + DepthW'(1);
						frame_n.seen_open = 1'b1;
					end else if (word.cls.is_close) begin
						frame_n.depth = frame_q.depth - DepthW'(1);
					end
					if (word.last && frame_n.seen_open && frame_n.depth == '0 &&
						!frame_n.in_str) begin
						emit    = 1'b1;
						present = (frame_n.phase == jfx_pkg::PH_FOUND) ||
							((frame_n.phase == jfx_pkg::PH_DIGITS) &&
							!(frame_n.neg && frame_n.mag != '0));
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			drop_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			frame_q <= emit ? '0 : frame_n;
			drop_q  <= drop_n;
			if (emit) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// hold the result payload until it is taken
	always_ff @(posedge clk) begin
		if (emit) begin
			len_q     <= 12'(frame_n.fill);
			present_q <= present;
			number_q  <= present ? frame_n.mag : '0;
		end
	end

	assign result_valid = valid_q;
	assign frame_length = len_q;
	assign id_present   = present_q;
	assign id_number    = number_q;

endmodule

>>> rtl/core/json_frame_and_id_extractor_core.sv
// JSON frame and id extractor.
// Input channel (data_valid / data_stall) carries one payload byte per word with
// first_of_chunk, chunk_bytes (read on the first byte) and last_of_chunk markers.
// Output channel (result_valid / result_stall) carries one word per completed
// frame: frame_length, id_present and id_number (zero when no id was found).
// Throughput: one byte per cycle while no result is held by result_stall. The
// front classifies each byte, a two-entry queue decouples it from the back,
// which updates depth, string and id state for each byte and loads the output
// register. The last byte of a frame is first written into the queue; the back
// then pops it and registers the result into the output register.
// Chunks that would overflow BUFFER_BYTES are dropped and the frame restarts
// with no result.
// Reset clears the frame state, the queue pointers and the result valid flag;
// the result payload is not reset. No clearing pass is needed.
// While result_stall is high and a result is held, the back stops, the queue fills
// and data_stall rises once both entries are taken.
module json_frame_and_id_extractor_core #(
	parameter int BUFFER_BYTES = jfx_pkg::BufferBytesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic  [7:0] data_byte,
	input  logic        first_of_chunk,
	input  logic  [7:0] chunk_bytes,
	input  logic        last_of_chunk,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [11:0] frame_length,
	output logic        id_present,
	output logic [30:0] id_number
);

	jfx_pkg::word_t front_word;
	jfx_pkg::word_t back_word;
	logic           back_valid;
	logic           back_stall;

	jfx_front u_front (
		.data_byte      (data_byte),
		.first_of_chunk (first_of_chunk),
		.chunk_bytes    (chunk_bytes),
		.last_of_chunk  (last_of_chunk),
		.word           (front_word)
	);

	jfx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (data_valid),
		.push_stall (data_stall),
		.push_word  (front_word),
		.pop_valid  (back_valid),
		.pop_stall  (back_stall),
		.pop_word   (back_word)
	);

	jfx_back #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (back_valid),
		.word_stall   (back_stall),
		.word         (back_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.frame_length (frame_length),
		.id_present   (id_present),
		.id_number    (id_number)
	);

endmodule
